[rtl/prru_pkg.sv]
package prru_pkg;

	localparam int ELEM_W    = 4;   // bits per packed element
	localparam int PERM_W    = 64;  // packed permutation width
	localparam int RANK_W    = 45;  // rank width, holds 16!
	localparam int SIZE_W    = 5;   // size register width
	localparam int DIV_W     = 48;  // dividend register, rank padded to whole chunks
	localparam int DIV_BITS  = 8;   // quotient bits retired per divider cycle
	localparam int DIV_STEPS = DIV_W / DIV_BITS;
	localparam int DC_W      = $clog2(DIV_STEPS);
	localparam int REM_W     = ELEM_W + 1;  // partial remainder before the subtract

	// n! for n = 0..16; larger codes never reach here after clamping
	function automatic logic [RANK_W-1:0] fact(input logic [SIZE_W-1:0] n);
		logic [RANK_W-1:0] f;
		unique case (n)
			5'd0:    f = 45'd1;
			5'd1:    f = 45'd1;
			5'd2:    f = 45'd2;
			5'd3:    f = 45'd6;
			5'd4:    f = 45'd24;
			5'd5:    f = 45'd120;
			5'd6:    f = 45'd720;
			5'd7:    f = 45'd5040;
			5'd8:    f = 45'd40320;
			5'd9:    f = 45'd362880;
			5'd10:   f = 45'd3628800;
			5'd11:   f = 45'd39916800;
			5'd12:   f = 45'd479001600;
			5'd13:   f = 45'd6227020800;
			5'd14:   f = 45'd87178291200;
			5'd15:   f = 45'd1307674368000;
			5'd16:   f = 45'd20922789888000;
			default: f = 45'd20922789888000;
		endcase
		return f;
	endfunction

endpackage

[rtl/permutation_rank_unrank_top.sv]
// Permutation rank / unrank engine (linear-time swap method).
// Command channel: present command, perm_in and rank_in with start high; the
// transaction is taken at a rising edge where start is high and busy is low.
// command 0 ranks perm_in (4 bits per element, element 0 in bits 3:0);
// command 1 unranks rank_in into perm_out (unused nibbles zero).
// Result channel: done pulses high for exactly one cycle with rank_out,
// perm_out and error valid; the receiver cannot stall, so sample on done.
// busy drops in the same cycle that done is shown, so the next transaction
// may be started while a result is on the ports.
// Sequence, n = effective size (size register clamped to 1..MAX_SIZE):
//   rank:   a load/check step per element, then a swap step for each k from
//           n down to 2 (none for n = 1); a bad element ends the load early;
//   unrank: for each element, a run of the shared divider (8 quotient bits a
//           cycle over a 48-bit dividend) then one swap step. A rank of
//           n! or more is flagged in the cycle after accept.
// Write the size register through cfg_we/cfg_data only while idle. Reset
// returns the sequencer to idle, clears done and sets the size to 16.
module permutation_rank_unrank_top #(
	parameter int MAX_SIZE = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [prru_pkg::SIZE_W-1:0]       cfg_data,
	input  logic                              start,
	output logic                              busy,
	input  logic                              command,
	input  logic [prru_pkg::PERM_W-1:0]       perm_in,
	input  logic [prru_pkg::RANK_W-1:0]       rank_in,
	output logic                              done,
	output logic [prru_pkg::RANK_W-1:0]       rank_out,
	output logic [prru_pkg::PERM_W-1:0]       perm_out,
	output logic                              error
);

	localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
	localparam int CNT_W = $clog2(MAX_SIZE + 1);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_RSTEP = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_SWAP  = 3'd4;

	// control state
	logic [2:0]                       state_q;
	logic [CNT_W-1:0]                 cnt_q;
	logic [prru_pkg::DC_W-1:0]        dc_q;
	logic [CNT_W-1:0]                 n_q;
	logic [prru_pkg::SIZE_W-1:0]      size_q;
	logic                             done_q;

	// working storage
	logic [prru_pkg::PERM_W-1:0]      perm_q;
	logic [prru_pkg::DIV_W-1:0]       div_q;
	logic [prru_pkg::ELEM_W-1:0]      rem_q;
	logic [prru_pkg::RANK_W-1:0]      acc_q;
	logic [prru_pkg::RANK_W-1:0]      mult_q;
	logic [IDX_W-1:0]                 tmp_q;
	logic [IDX_W-1:0]                 p_q [MAX_SIZE];
	logic [IDX_W-1:0]                 q_q [MAX_SIZE];
	logic [IDX_W-1:0]                 e_q [MAX_SIZE];
	logic [MAX_SIZE-1:0]              seen_q;
	logic [prru_pkg::RANK_W-1:0]      rank_out_q;
	logic [prru_pkg::PERM_W-1:0]      perm_out_q;
	logic                             error_q;

	logic                             accept;
	logic                             fin_now;
	logic [CNT_W-1:0]                 n_eff;
	logic                             unr_bad;
	logic [CNT_W-1:0]                 km1_full;
	logic [IDX_W-1:0]                 km1;
	logic [IDX_W-1:0]                 cnt_idx;
	logic [prru_pkg::ELEM_W-1:0]      ld_val;
	logic [IDX_W-1:0]                 ld_idx;
	logic                             ld_bad;
	logic                             ld_last;
	logic [IDX_W-1:0]                 s_val;
	logic [IDX_W-1:0]                 j_val;
	logic [prru_pkg::RANK_W-1:0]      acc_nx;
	logic [prru_pkg::RANK_W-1:0]      mult_nx;
	logic [prru_pkg::DIV_W-1:0]       div_nx;
	logic [prru_pkg::REM_W-1:0]       rem_w;
	logic [prru_pkg::ELEM_W-1:0]      rem_nx;
	logic [IDX_W-1:0]                 j_u;
	logic [IDX_W-1:0]                 e_addr;
	logic [IDX_W-1:0]                 e_rd;
	logic [prru_pkg::PERM_W-1:0]      perm_nx;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign done     = done_q;
	assign rank_out = rank_out_q;
	assign perm_out = perm_out_q;
	assign error    = error_q;

	// clamp the size register into 1..MAX_SIZE
	always_comb begin
		if (size_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (size_q > prru_pkg::SIZE_W'(MAX_SIZE)) begin
			n_eff = CNT_W'(MAX_SIZE);
		end else begin
			n_eff = CNT_W'(size_q);
		end
	end

	assign unr_bad = (rank_in >= prru_pkg::fact(prru_pkg::SIZE_W'(n_eff)));

	assign km1_full = cnt_q - CNT_W'(1);
	assign km1      = km1_full[IDX_W-1:0];
	assign cnt_idx  = cnt_q[IDX_W-1:0];

	// load/check: one element a cycle; out of range or repeated aborts
	assign ld_val  = perm_q[cnt_idx*prru_pkg::ELEM_W +: prru_pkg::ELEM_W];
	assign ld_idx  = ld_val[IDX_W-1:0];
	assign ld_bad  = (prru_pkg::SIZE_W'(ld_val) >= prru_pkg::SIZE_W'(n_q)) || seen_q[ld_idx];
	assign ld_last = (cnt_q == n_q - CNT_W'(1));

	// finish the transaction at this edge: the result shows next cycle
	always_comb begin
		unique case (state_q)
			ST_IDLE:  fin_now = accept && command && unr_bad;
			ST_LOAD:  fin_now = ld_bad || (ld_last && n_q == CNT_W'(1));
			ST_RSTEP: fin_now = (cnt_q == CNT_W'(2));
			ST_SWAP:  fin_now = (cnt_q == CNT_W'(1));
			default:  fin_now = 1'b0;
		endcase
	end

	// rank step k: s = p[k-1], j = q[k-1]; slot k-1 of both arrays is dead
	// afterwards, so only p[j] and q[s] need writing
	assign s_val   = p_q[km1];
	assign j_val   = q_q[km1];
	assign acc_nx  = acc_q + prru_pkg::RANK_W'(mult_q * prru_pkg::RANK_W'(s_val));
	assign mult_nx = prru_pkg::RANK_W'(mult_q * prru_pkg::RANK_W'(cnt_q));

	// shared divider: restoring division by k, DIV_BITS quotient bits a cycle
	always_comb begin
		div_nx = div_q;
		rem_w  = prru_pkg::REM_W'(rem_q);
		for (int b = 0; b < prru_pkg::DIV_BITS; b++) begin
			rem_w  = {rem_w[prru_pkg::REM_W-2:0], div_nx[prru_pkg::DIV_W-1]};
			div_nx = {div_nx[prru_pkg::DIV_W-2:0], 1'b0};
			if (rem_w >= prru_pkg::REM_W'(cnt_q)) begin
				rem_w     = rem_w - prru_pkg::REM_W'(cnt_q);
				div_nx[0] = 1'b1;
			end
		end
		rem_nx = rem_w[prru_pkg::ELEM_W-1:0];
	end

	// element array has one read port: slot k-1 while dividing, slot r mod k
	// in the swap cycle
	assign j_u    = rem_q[IDX_W-1:0];
	assign e_addr = (state_q == ST_SWAP) ? j_u : km1;
	assign e_rd   = e_q[e_addr];

	always_comb begin
		perm_nx = perm_q;
		perm_nx[km1*prru_pkg::ELEM_W +: prru_pkg::ELEM_W] = prru_pkg::ELEM_W'(e_rd);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			dc_q    <= '0;
			n_q     <= CNT_W'(1);
			size_q  <= prru_pkg::SIZE_W'(16);
			done_q  <= 1'b0;
		end else begin
			done_q <= fin_now;
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						n_q <= n_eff;
						if (!command) begin
							cnt_q   <= '0;
							state_q <= ST_LOAD;
						end else if (!unr_bad) begin
							cnt_q   <= n_eff;
							dc_q    <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_LOAD: begin
					if (ld_bad) begin
						state_q <= ST_IDLE;
					end else if (ld_last) begin
						if (n_q == CNT_W'(1)) begin
							state_q <= ST_IDLE;
						end else begin
							cnt_q   <= n_q;
							state_q <= ST_RSTEP;
						end
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_RSTEP: begin
					if (cnt_q == CNT_W'(2)) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= km1_full;
					end
				end
				ST_DIV: begin
					if (dc_q == prru_pkg::DC_W'(prru_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_SWAP;
					end else begin
						dc_q <= dc_q + prru_pkg::DC_W'(1);
					end
				end
				ST_SWAP: begin
					if (cnt_q == CNT_W'(1)) begin
						state_q <= ST_IDLE;
					end else begin
						cnt_q   <= km1_full;
						dc_q    <= '0;
						state_q <= ST_DIV;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					perm_q <= command ? '0 : perm_in;
					div_q  <= prru_pkg::DIV_W'(rank_in);
					rem_q  <= '0;
					acc_q  <= '0;
					mult_q <= prru_pkg::RANK_W'(1);
					seen_q <= '0;
					for (int i = 0; i < MAX_SIZE; i++) begin
						e_q[i] <= IDX_W'(i);
					end
					if (command && unr_bad) begin
						rank_out_q <= '0;
						perm_out_q <= '0;
						error_q    <= 1'b1;
					end
				end
			end
			ST_LOAD: begin
				if (ld_bad) begin
					rank_out_q <= '0;
					perm_out_q <= '0;
					error_q    <= 1'b1;
				end else begin
					p_q[cnt_idx]   <= ld_idx;
					q_q[ld_idx]    <= cnt_idx;
					seen_q[ld_idx] <= 1'b1;
					if (ld_last && n_q == CNT_W'(1)) begin
						rank_out_q <= '0;
						perm_out_q <= '0;
						error_q    <= 1'b0;
					end
				end
			end
			ST_RSTEP: begin
				p_q[j_val] <= s_val;
				q_q[s_val] <= j_val;
				acc_q      <= acc_nx;
				mult_q     <= mult_nx;
				if (cnt_q == CNT_W'(2)) begin
					rank_out_q <= acc_nx;
					perm_out_q <= '0;
					error_q    <= 1'b0;
				end
			end
			ST_DIV: begin
				div_q <= div_nx;
				rem_q <= rem_nx;
				if (dc_q == '0) begin
					tmp_q <= e_rd;
				end
			end
			ST_SWAP: begin
				perm_q   <= perm_nx;
				e_q[j_u] <= tmp_q;
				rem_q    <= '0;
				if (cnt_q == CNT_W'(1)) begin
					rank_out_q <= '0;
					perm_out_q <= perm_nx;
					error_q    <= 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// a result is only ever shown with the sequencer back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("done raised while sequencer busy");

	// an error result carries zero payload
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && error) |-> (rank_out == '0 && perm_out == '0))
		else $error("error result with nonzero payload");

	// an accepted transaction either works on or reports in the next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy || done))
		else $error("accepted transaction dropped");

	// the divider never runs with a zero divisor
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV || state_q == ST_SWAP) |-> (cnt_q != '0))
		else $error("divide step with zero divisor");

endmodule

[verif/permutation_rank_unrank_top_test.sv]
module permutation_rank_unrank_top_test;

	import prru_pkg::*;

	localparam int MAX_SIZE = 16;
	// several times the slowest correct run: every item an unrank at full size
	// plus the longest sender gap, plus the drains around each size change
	localparam int CYCLE_LIMIT = 1_000_000;

	// command codes on the command port
	typedef enum logic {
		CMD_RANK   = 1'b0,
		CMD_UNRANK = 1'b1
	} cmd_e;

	// one result transaction as the block should present it
	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic [PERM_W-1:0] perm;
		logic              err;
	} outcome_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [SIZE_W-1:0] cfg_data;
	logic              start;
	logic              busy;
	logic              command;
	logic [PERM_W-1:0] perm_in;
	logic [RANK_W-1:0] rank_in;
	logic              done;
	logic [RANK_W-1:0] rank_out;
	logic [PERM_W-1:0] perm_out;
	logic              error;

	// results owed by the block, oldest first
	outcome_t pending_results[$];

	// our copy of the size register
	logic [SIZE_W-1:0] size_reg = 5'd16;

	int unsigned mismatches    = 0;
	int unsigned results_seen  = 0;
	int unsigned flagged_seen  = 0;
	int unsigned ranks_sent    = 0;
	int unsigned unranks_sent  = 0;
	int unsigned size_writes   = 0;
	int unsigned cycles_run    = 0;

	// sender pacing: bursts of back-to-back transactions split by idle gaps
	bit          idling_on  = 1'b1;
	int unsigned burst_left = 0;

	permutation_rank_unrank_top #(
		.MAX_SIZE(MAX_SIZE)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.start    (start),
		.busy     (busy),
		.command  (command),
		.perm_in  (perm_in),
		.rank_in  (rank_in),
		.done     (done),
		.rank_out (rank_out),
		.perm_out (perm_out),
		.error    (error)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Prediction
	// ------------------------------------------------------------------

	// the block clamps the register to 1..MAX_SIZE
	function automatic int unsigned eff_size(logic [SIZE_W-1:0] sz);
		if (sz == 0)
			return 1;
		if (sz > MAX_SIZE)
			return MAX_SIZE;
		return 32'(sz);
	endfunction

	// n!, the number of permutations of size n
	function automatic logic [63:0] perm_count(int unsigned n);
		logic [63:0] f;
		f = 64'd1;
		for (int unsigned k = 2; k <= n; k++)
			f = f * k;
		return f;
	endfunction

	// swap-based linear-time rank / unrank of one transaction
	function automatic outcome_t predict_outcome(logic [SIZE_W-1:0] sz, cmd_e cmd,
			logic [PERM_W-1:0] p_in, logic [RANK_W-1:0] r_in);
		outcome_t    o;
		int unsigned n;
		logic [3:0]  v, t, s, j;
		logic [3:0]  elem [MAX_SIZE];
		logic [3:0]  where [MAX_SIZE];
		bit          seen [MAX_SIZE];
		bit          bad;
		logic [63:0] acc, mult, rr;
		o = '0;
		n = eff_size(sz);
		if (cmd == CMD_RANK) begin
			bad = 1'b0;
			for (int unsigned i = 0; i < MAX_SIZE; i++)
				seen[i] = 1'b0;
			// nibbles at and above element n are ignored
			for (int unsigned i = 0; i < n; i++) begin
				v = p_in[4*i +: 4];
				if (v >= n || seen[v])
					bad = 1'b1;
				else begin
					seen[v]  = 1'b1;
					elem[i]  = v;
					where[v] = 4'(i);
				end
			end
			if (bad) begin
				o.err = 1'b1;
			end else begin
				acc  = 64'd0;
				mult = 64'd1;
				for (int k = n; k >= 2; k--) begin
					s            = elem[k-1];
					j            = where[k-1];
					t            = elem[k-1];
					elem[k-1]    = elem[j];
					elem[j]      = t;
					t            = where[s];
					where[s]     = where[k-1];
					where[k-1]   = t;
					acc          = acc + s * mult;
					mult         = mult * k;
				end
				o.rank = acc[RANK_W-1:0];
			end
		end else begin
			rr = {{(64-RANK_W){1'b0}}, r_in};
			if (rr >= perm_count(n)) begin
				o.err = 1'b1;
			end else begin
				for (int unsigned i = 0; i < n; i++)
					elem[i] = 4'(i);
				for (int k = n; k >= 1; k--) begin
					j         = 4'(rr % k);
					t         = elem[k-1];
					elem[k-1] = elem[j];
					elem[j]   = t;
					rr        = rr / k;
				end
				for (int unsigned i = 0; i < n; i++)
					o.perm[4*i +: 4] = elem[i];
			end
		end
		return o;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [63:0] wide_random();
		return {$urandom, $urandom};
	endfunction

	// a valid permutation of size n in the low nibbles; the unused nibbles
	// above carry noise when asked, so they toggle without changing the result
	function automatic logic [PERM_W-1:0] shuffled_perm(int unsigned n, bit noisy);
		logic [PERM_W-1:0] packed_p;
		logic [3:0]        elem [MAX_SIZE];
		logic [3:0]        t;
		int unsigned       j;
		packed_p = noisy ? wide_random() : '0;
		for (int unsigned i = 0; i < n; i++)
			elem[i] = 4'(i);
		for (int i = n - 1; i >= 1; i--) begin
			j       = $urandom_range(0, i);
			t       = elem[i];
			elem[i] = elem[j];
			elem[j] = t;
		end
		for (int unsigned i = 0; i < n; i++)
			packed_p[4*i +: 4] = elem[i];
		return packed_p;
	endfunction

	// break one element: out of range or a repeat, at random where both exist
	function automatic logic [PERM_W-1:0] broken_perm(int unsigned n, bit noisy);
		logic [PERM_W-1:0] packed_p;
		int unsigned       i, j;
		packed_p = shuffled_perm(n, noisy);
		i = $urandom_range(0, n - 1);
		if (n < MAX_SIZE && (n < 2 || $urandom_range(0, 1) == 1)) begin
			packed_p[4*i +: 4] = 4'($urandom_range(n, 15));
		end else begin
			j = (i + $urandom_range(1, n - 1)) % n;
			packed_p[4*i +: 4] = packed_p[4*j +: 4];
		end
		return packed_p;
	endfunction

	// a rank from n! up to the top of the rank field
	function automatic logic [RANK_W-1:0] oversized_rank(int unsigned n);
		logic [63:0] span;
		span = (64'd1 << RANK_W) - perm_count(n);
		return RANK_W'(perm_count(n) + wide_random() % span);
	endfunction

	// ------------------------------------------------------------------
	// Driver side
	// ------------------------------------------------------------------

	// Present one transaction and hold it until the block takes it. Called at
	// a rising edge; returns at the edge that accepted it.
	task automatic send_item(cmd_e c, logic [PERM_W-1:0] p, logic [RANK_W-1:0] r);
		start   <= 1'b1;
		command <= c;
		perm_in <= p;
		rank_in <= r;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		// accepted at this edge: record what it must produce
		pending_results.push_back(predict_outcome(size_reg, c, p, r));
		if (c == CMD_RANK)
			ranks_sent++;
		else
			unranks_sent++;
	endtask

	// drop start for a random gap at the end of each burst
	task automatic pace();
		if (!idling_on)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		start <= 1'b0;
		repeat ($urandom_range(1, 12)) @(posedge clk);
		burst_left = $urandom_range(0, 20);
	endtask

	// wait until every owed result is in and the block has gone quiet
	task automatic settle(int unsigned tail);
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// write the size register; only ever called after settle
	task automatic write_size(logic [SIZE_W-1:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		size_reg = value;
		size_writes++;
		cfg_we   <= 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		$display("mismatch on %s at result %0d: got %h, want %h",
			what, results_seen, got, want);
	endtask

	// the receiver cannot stall, so every strobe is taken at the edge ending it
	always @(posedge clk) begin
		outcome_t want;
		if (arst_n && done) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", {19'd0, rank_out}, 64'd0);
			end else begin
				want = pending_results.pop_front();
				if (want.err)
					flagged_seen++;
				if (rank_out !== want.rank)
					report_mismatch("rank_out", {19'd0, rank_out}, {19'd0, want.rank});
				if (perm_out !== want.perm)
					report_mismatch("perm_out", perm_out, want.perm);
				if (error !== want.err)
					report_mismatch("error", {63'd0, error}, {63'd0, want.err});
			end
		end
	end

	// hang guard
	initial begin
		while (cycles_run < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("permutation_rank_unrank_top regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// reset size of 16: identity, reversal, bad permutations, rank limits
	task automatic test_reset_size();
		send_item(CMD_RANK, 64'hFEDC_BA98_7654_3210, '0);
		send_item(CMD_RANK, 64'h0123_4567_89AB_CDEF, '1);
		send_item(CMD_RANK, 64'hFFFF_FFFF_FFFF_FFFF, '0);
		send_item(CMD_RANK, 64'h0000_0000_0000_0000, '0);
		send_item(CMD_UNRANK, '1, '0);
		send_item(CMD_UNRANK, '0, RANK_W'(perm_count(16) - 1));
		send_item(CMD_UNRANK, '0, RANK_W'(perm_count(16)));
		send_item(CMD_UNRANK, '0, '1);
		settle(8);
	endtask

	// size of 0 acts as 1, size above the maximum acts as the maximum
	task automatic test_size_clamp();
		write_size(5'd0);
		send_item(CMD_RANK, 64'hFFFF_FFFF_FFFF_FFF0, '0);
		send_item(CMD_RANK, 64'h0000_0000_0000_0001, '0);
		send_item(CMD_UNRANK, '0, '0);
		send_item(CMD_UNRANK, '0, RANK_W'(1));
		settle(8);
		write_size(5'd31);
		send_item(CMD_RANK, 64'hFEDC_BA98_7654_3210, '0);
		send_item(CMD_UNRANK, '0, RANK_W'(perm_count(16) - 1));
		settle(8);
		write_size(5'd1);
		send_item(CMD_UNRANK, '1, '0);
		send_item(CMD_RANK, '0, '1);
		settle(8);
	endtask

	// size 2: both orders, a repeat, and the first rank past the end
	task automatic test_two_elements();
		write_size(5'd2);
		send_item(CMD_RANK, 64'h10, '0);
		send_item(CMD_RANK, 64'h01, '0);
		send_item(CMD_RANK, 64'h11, '0);
		send_item(CMD_UNRANK, '0, RANK_W'(1));
		send_item(CMD_UNRANK, '0, RANK_W'(2));
		settle(8);
	endtask

	// one random transaction at size n, mostly well-formed
	task automatic send_random_item(int unsigned n);
		int unsigned pick;
		bit          noisy;
		pick  = $urandom_range(0, 99);
		noisy = 1'($urandom_range(0, 1));
		if (pick < 45)
			send_item(CMD_RANK, shuffled_perm(n, noisy), RANK_W'(wide_random()));
		else if (pick < 58)
			send_item(CMD_RANK, broken_perm(n, noisy), RANK_W'(wide_random()));
		else if (pick < 88)
			send_item(CMD_UNRANK, wide_random(), RANK_W'(wide_random() % perm_count(n)));
		else if (pick < 94)
			send_item(CMD_UNRANK, wide_random(), oversized_rank(n));
		else
			send_item(CMD_UNRANK, wide_random(), RANK_W'(wide_random()));
		pace();
	endtask

	// random traffic over the extreme sizes, a few middle ones and random ones
	task automatic test_random_traffic();
		logic [SIZE_W-1:0] sizes [8] = '{5'd16, 5'd1, 5'd3, 5'd0, 5'd31, 5'd8, 5'd15, 5'd2};
		logic [SIZE_W-1:0] sz;
		for (int phase = 0; phase < 12; phase++) begin
			sz = (phase < 8) ? sizes[phase] : SIZE_W'($urandom_range(0, 31));
			write_size(sz);
			// two phases run with no sender gaps at all
			idling_on  = !(phase == 2 || phase == 6);
			burst_left = $urandom_range(0, 20);
			repeat (78)
				send_random_item(eff_size(sz));
			settle(8);
		end
	endtask

	initial begin
		arst_n   <= 1'b0;
		cfg_we   <= 1'b0;
		cfg_data <= '0;
		start    <= 1'b0;
		command  <= CMD_RANK;
		perm_in  <= '0;
		rank_in  <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_size();
		test_size_clamp();
		test_two_elements();
		test_random_traffic();

		// the slowest transaction is an unrank at full size
		settle(8 * MAX_SIZE);

		$display("covered %0d rank and %0d unrank transactions over %0d size writes",
			ranks_sent, unranks_sent, size_writes);
		$display("%0d results checked, %0d flagged invalid, %0d mismatches",
			results_seen, flagged_seen, mismatches);
		if (mismatches == 0)
			$display("permutation_rank_unrank_top regression: pass");
		else
			$display("permutation_rank_unrank_top regression: fail");
		$finish;
	end

endmodule
